// File: rtl/dhte_pkg.sv
// shared types and codes for the double hash table engine
// no dependencies; used by the top level, dhte_front and dhte_back
`default_nettype none

package dhte_pkg;

	localparam int CFG_W = 11;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CMD_W = 2;
	localparam int SLOT_W = 10;

	// configuration register indexes
	localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
	localparam logic [1:0] REG_REHASH_MOD = 2'd1;

	// commands
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	// unused code, behaves as a lookup
	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

	// slot states
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_LIVE  = 2'd1;
	localparam logic [1:0] ST_TOMB  = 2'd2;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MOD_SIZE,
		F_MOD_REHASH,
		F_MOD_STEP,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE,
		B_CHECK,
		B_FINISH
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/double_hash_table_engine.sv
// top level of the double hash table engine: config registers, front, queue, back
// depends on dhte_pkg, dhte_front, dhte_fifo, dhte_back, dhte_ram
`default_nettype none

// Open-addressed hash table with double hashing over MAX_SLOTS slots, each
// holding a 32-bit key, a 32-bit value and a sync mark. Commands enter through
// push/full and results leave through empty/pop, one result per command, in
// order. After reset the block sweeps the slot state memory once, all MAX_SLOTS
// slots, with full held high; configuration writes are taken throughout.
// The front works out the first slot and the probe step with one bit-serial
// remainder unit in three passes (two when rehash_mod is zero), and takes no
// new command until the job of the last one has gone into the queue.
// The back reads each probed slot from memory, then compares it; it also
// takes the job first and posts the result last. Front and back overlap
// through a two-entry queue.
// Change table_size or rehash_mod only while no command is in flight.

module double_hash_table_engine import dhte_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_addr,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [CMD_W-1:0]   cmd,
	input  wire logic [KEY_W-1:0]   key,
	input  wire logic [VAL_W-1:0]   value,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    hit,
	output logic      [VAL_W-1:0]   found_value,
	output logic                    needs_sync,
	output logic      [SLOT_W-1:0]  slot,
	output logic      [CFG_W-1:0]   entry_count,
	output logic                    status
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int SW = AW + 1;
	localparam int JW = CMD_W + KEY_W + VAL_W + SW + AW + AW;

	logic [CFG_W-1:0] table_size_q, rehash_mod_q;
	logic             clearing, q_push, q_full, q_empty, job_pop;
	logic [CMD_W-1:0] f_cmd, b_cmd;
	logic [KEY_W-1:0] f_key, b_key;
	logic [VAL_W-1:0] f_value, b_value;
	logic [SW-1:0]    f_size, b_size;
	logic [AW-1:0]    f_pos, f_step, b_pos, b_step;
	logic [JW-1:0]    q_din, q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= CFG_W'(1021);
			rehash_mod_q <= CFG_W'(1019);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TABLE_SIZE: table_size_q <= cfg_data;
				REG_REHASH_MOD: rehash_mod_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dhte_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.key        (key),
		.value      (value),
		.table_size (table_size_q),
		.rehash_mod (rehash_mod_q),
		.hold       (clearing),
		.q_push     (q_push),
		.q_full     (q_full),
		.j_cmd      (f_cmd),
		.j_key      (f_key),
		.j_value    (f_value),
		.j_size     (f_size),
		.j_pos      (f_pos),
		.j_step     (f_step)
	);

	assign q_din = {f_cmd, f_key, f_value, f_size, f_pos, f_step};

	dhte_fifo #(.W(JW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.pop    (job_pop),
		.empty  (q_empty),
		.din    (q_din),
		.dout   (q_dout)
	);

	assign {b_cmd, b_key, b_value, b_size, b_pos, b_step} = q_dout;

	dhte_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (!q_empty),
		.job_pop     (job_pop),
		.j_cmd       (b_cmd),
		.j_key       (b_key),
		.j_value     (b_value),
		.j_size      (b_size),
		.j_pos       (b_pos),
		.j_step      (b_step),
		.clearing    (clearing),
		.pop         (pop),
		.empty       (empty),
		.hit         (hit),
		.found_value (found_value),
		.needs_sync  (needs_sync),
		.slot        (slot),
		.entry_count (entry_count),
		.status      (status)
	);

endmodule

`default_nettype wire

// File: rtl/dhte_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
`default_nettype none

module dhte_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/dhte_fifo.sv
// two entry queue between the front and the back part
// no dependencies
`default_nettype none

module dhte_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] data_q [2];
	logic         wptr_q, rptr_q;
	logic [1:0]   count_q;
	logic         do_push, do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = data_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop) rptr_q <= ~rptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// File: rtl/dhte_front.sv
// front part: takes commands, works out first slot and probe step with a
// shared bit-serial remainder unit; depends on dhte_pkg
`default_nettype none

module dhte_front import dhte_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [CMD_W-1:0]             cmd,
	input  wire logic [KEY_W-1:0]             key,
	input  wire logic [VAL_W-1:0]             value,
	input  wire logic [CFG_W-1:0]             table_size,
	input  wire logic [CFG_W-1:0]             rehash_mod,
	input  wire logic                         hold,
	output logic                              q_push,
	input  wire logic                         q_full,
	output logic      [CMD_W-1:0]             j_cmd,
	output logic      [KEY_W-1:0]             j_key,
	output logic      [VAL_W-1:0]             j_value,
	output logic      [$clog2(MAX_SLOTS):0]   j_size,
	output logic      [$clog2(MAX_SLOTS)-1:0] j_pos,
	output logic      [$clog2(MAX_SLOTS)-1:0] j_step
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int SW = AW + 1;
	localparam int DW = (SW > CFG_W) ? SW : CFG_W;

	front_state_t   state_q, state_d;
	logic [4:0]     cnt_q;
	logic [31:0]    dvd_q;
	logic [DW-1:0]  rem_q, div_q, rem_nxt, raw_step;
	logic [DW:0]    trial;
	logic [SW-1:0]  size_q, size_clamp;
	logic [CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0]  pos_q, step_q;
	logic           accept, last_bit;

	// one quotient bit per cycle
	assign trial    = {rem_q, dvd_q[31]};
	assign rem_nxt  = (trial >= {1'b0, div_q}) ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
	assign raw_step = (rem_nxt == '0) ? DW'(1) : rem_nxt;
	assign last_bit = (cnt_q == 5'd0);
	assign accept   = push && !full;

	always_comb begin
		if (table_size == '0) size_clamp = SW'(1);
		else if (32'(table_size) > 32'(MAX_SLOTS)) size_clamp = SW'(MAX_SLOTS);
		else size_clamp = SW'(table_size);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_MOD_SIZE;
			end
			F_MOD_SIZE: begin
				if (last_bit) state_d = (rehash_mod == '0) ? F_MOD_STEP : F_MOD_REHASH;
			end
			F_MOD_REHASH: begin
				if (last_bit) state_d = F_MOD_STEP;
			end
			F_MOD_STEP: begin
				if (last_bit) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		full   = (state_q != F_IDLE) || hold;
		q_push = (state_q == F_PUSH) && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					cmd_q  <= cmd;
					key_q  <= key;
					val_q  <= value;
					size_q <= size_clamp;
					dvd_q  <= key;
					rem_q  <= '0;
					div_q  <= DW'(size_clamp);
					cnt_q  <= 5'd31;
				end
			end
			F_MOD_SIZE: begin
				if (last_bit) begin
					pos_q <= AW'(rem_nxt);
					rem_q <= '0;
					cnt_q <= 5'd31;
					if (rehash_mod == '0) begin
						// zero modulus gives a step of one, reduced modulo the table size
						dvd_q <= 32'd1;
					end else begin
						dvd_q <= key_q;
						div_q <= DW'(rehash_mod);
					end
				end else begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_nxt;
					cnt_q <= cnt_q - 5'd1;
				end
			end
			F_MOD_REHASH: begin
				if (last_bit) begin
					dvd_q <= 32'(raw_step);
					div_q <= DW'(size_q);
					rem_q <= '0;
					cnt_q <= 5'd31;
				end else begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_nxt;
					cnt_q <= cnt_q - 5'd1;
				end
			end
			F_MOD_STEP: begin
				if (last_bit) begin
					step_q <= AW'(rem_nxt);
				end else begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_nxt;
					cnt_q <= cnt_q - 5'd1;
				end
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	assign j_cmd   = cmd_q;
	assign j_key   = key_q;
	assign j_value = val_q;
	assign j_size  = size_q;
	assign j_pos   = pos_q;
	assign j_step  = step_q;

endmodule

`default_nettype wire

// File: rtl/dhte_back.sv
// back part: clears the slot table after reset, walks the probe sequence,
// applies the command and holds the result; depends on dhte_pkg, dhte_ram
`default_nettype none

module dhte_back import dhte_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         job_valid,
	output logic                              job_pop,
	input  wire logic [CMD_W-1:0]             j_cmd,
	input  wire logic [KEY_W-1:0]             j_key,
	input  wire logic [VAL_W-1:0]             j_value,
	input  wire logic [$clog2(MAX_SLOTS):0]   j_size,
	input  wire logic [$clog2(MAX_SLOTS)-1:0] j_pos,
	input  wire logic [$clog2(MAX_SLOTS)-1:0] j_step,
	output logic                              clearing,
	input  wire logic                         pop,
	output logic                              empty,
	output logic                              hit,
	output logic      [VAL_W-1:0]             found_value,
	output logic                              needs_sync,
	output logic      [SLOT_W-1:0]            slot,
	output logic      [CFG_W-1:0]             entry_count,
	output logic                              status
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int SW = AW + 1;
	localparam int KVW = KEY_W + VAL_W + 1;

	back_state_t    state_q, state_d;
	logic [AW-1:0]  addr_q, tomb_q, end_q, end_now, pos_next;
	logic [SW-1:0]  cnt_q, size_q, sum;
	logic [AW-1:0]  step_q;
	logic [CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q, fval_q;
	logic           have_tomb_q, live_q, fail_q, fsync_q;
	logic [CFG_W-1:0] filled_q, filled_new;
	logic           out_valid_q, out_free;
	logic [1:0]     rd_state, st_wdata;
	logic [KVW-1:0] rd_kv;
	logic           st_we, kv_we;
	logic [AW-1:0]  waddr;
	logic           is_tomb, is_live, done_now, live_now, fail_now;
	logic           do_ins, do_del;

	dhte_ram #(.W(2), .DEPTH(MAX_SLOTS)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (waddr),
		.wdata (st_wdata),
		.raddr (addr_q),
		.rdata (rd_state)
	);

	dhte_ram #(.W(KVW), .DEPTH(MAX_SLOTS)) u_kv_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (waddr),
		.wdata ({key_q, val_q, 1'b1}),
		.raddr (addr_q),
		.rdata (rd_kv)
	);

	assign out_free = !out_valid_q || pop;
	assign is_tomb  = (rd_state == ST_TOMB);
	assign is_live  = (rd_state == ST_LIVE);
	assign sum      = SW'(addr_q) + SW'(step_q);
	assign pos_next = (sum >= size_q) ? AW'(sum - size_q) : AW'(sum);
	assign do_ins   = (cmd_q == CMD_INSERT) && !fail_q;
	assign do_del   = (cmd_q == CMD_DELETE) && live_q;

	// probe decision on the slot just read
	always_comb begin
		done_now = 1'b0;
		live_now = 1'b0;
		fail_now = 1'b0;
		end_now  = addr_q;
		if (is_tomb) begin
			if (have_tomb_q && addr_q == tomb_q) begin
				done_now = 1'b1;
				end_now  = tomb_q;
			end
		end else if (is_live) begin
			if (rd_kv[KVW-1 -: KEY_W] == key_q) begin
				done_now = 1'b1;
				live_now = 1'b1;
			end
		end else begin
			// empty, and the unused state code counts as empty
			done_now = 1'b1;
			end_now  = have_tomb_q ? tomb_q : addr_q;
		end
		if (!done_now && cnt_q == size_q - SW'(1)) begin
			done_now = 1'b1;
			if (have_tomb_q) end_now = tomb_q;
			else if (is_tomb) end_now = addr_q;
			else fail_now = 1'b1;
		end
	end

	always_comb begin
		filled_new = filled_q;
		if (do_ins && !live_q) begin
			if (filled_q != '1) filled_new = filled_q + CFG_W'(1);
		end else if (do_del) begin
			if (filled_q != '0) filled_new = filled_q - CFG_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (addr_q == AW'(MAX_SLOTS - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (job_valid) state_d = B_PROBE;
			end
			B_PROBE: state_d = B_CHECK;
			B_CHECK: state_d = done_now ? B_FINISH : B_PROBE;
			B_FINISH: begin
				if (out_free) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		clearing = 1'b0;
		st_we    = 1'b0;
		kv_we    = 1'b0;
		st_wdata = ST_EMPTY;
		waddr    = end_q;
		case (state_q)
			B_CLEAR: begin
				clearing = 1'b1;
				st_we    = 1'b1;
				waddr    = addr_q;
			end
			B_IDLE: job_pop = job_valid;
			B_FINISH: begin
				if (out_free) begin
					if (do_ins) begin
						st_we    = 1'b1;
						kv_we    = 1'b1;
						st_wdata = ST_LIVE;
					end else if (do_del) begin
						st_we    = 1'b1;
						st_wdata = ST_TOMB;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			addr_q      <= '0;
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_FINISH && out_free) begin
				out_valid_q <= 1'b1;
				filled_q    <= filled_new;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: addr_q <= addr_q + AW'(1);
				B_IDLE: begin
					if (job_valid) addr_q <= j_pos;
				end
				B_CHECK: begin
					if (!done_now) addr_q <= pos_next;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					cmd_q       <= j_cmd;
					key_q       <= j_key;
					val_q       <= j_value;
					size_q      <= j_size;
					step_q      <= j_step;
					cnt_q       <= '0;
					have_tomb_q <= 1'b0;
				end
			end
			B_CHECK: begin
				if (done_now) begin
					end_q   <= end_now;
					live_q  <= live_now;
					fail_q  <= fail_now;
					fval_q  <= live_now ? rd_kv[VAL_W:1] : '0;
					fsync_q <= live_now && rd_kv[0];
				end else begin
					cnt_q <= cnt_q + SW'(1);
					if (is_tomb && !have_tomb_q) begin
						have_tomb_q <= 1'b1;
						tomb_q      <= addr_q;
					end
				end
			end
			B_FINISH: begin
				if (out_free) begin
					hit         <= live_q;
					found_value <= fval_q;
					needs_sync  <= fsync_q;
					slot        <= fail_q ? '0 : SLOT_W'(end_q);
					status      <= fail_q;
					entry_count <= filled_new;
				end
			end
			default: begin
			end
		endcase
	end

	assign empty = !out_valid_q;

	a_probe_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CHECK) |-> (SW'(addr_q) < size_q && cnt_q < size_q))
		else $error("probe left the table");

	a_count_moves_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(filled_q != $past(filled_q)) |-> $past(state_q == B_FINISH))
		else $error("entry count changed outside command completion");

	a_no_job_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> (!job_pop && !out_valid_q))
		else $error("work started during clearing pass");

	a_result_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FINISH && out_valid_q && !pop) |=> (state_q == B_FINISH))
		else $error("result overwritten before transfer");

endmodule

`default_nettype wire
